>>> hdl/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// Types, constants and helper functions for the reciprocal square root unit.
// ----------------------------------------------------------------------------
package fisr_pkg;

    localparam logic [31:0] MAGIC    = 32'h5F37_5A86;
    localparam logic [31:0] FP_HALF  = 32'h3F00_0000;
    localparam logic [31:0] FP_1P5   = 32'h3FC0_0000;
    localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;

    // Operand class after special-case screening.
    typedef enum logic [1:0] {
        CLS_NUM,
        CLS_ZERO,
        CLS_INF,
        CLS_NAN
    } t_cls;

    // Unrounded result handed to the rounding stage.
    typedef struct packed {
        logic        sign;
        t_cls        cls;
        logic        ovf;
        logic [7:0]  ef;
        logic [23:0] m;
        logic        g;
        logic        st;
    } t_rnd;

    function automatic t_cls fisr_class(input logic [31:0] v);
        t_cls c;
        if (v[30:23] == 8'hFF) begin
            c = (v[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
        end else if (v[30:0] == 31'd0) begin
            c = CLS_ZERO;
        end else begin
            c = CLS_NUM;
        end
        return c;
    endfunction

    function automatic logic [5:0] fisr_lzc48(input logic [47:0] v);
        logic [5:0] c;
        logic       f;
        c = 6'd0;
        f = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!f) begin
                if (v[i]) f = 1'b1;
                else      c = c + 6'd1;
            end
        end
        return c;
    endfunction

    function automatic logic [4:0] fisr_lzc27(input logic [26:0] v);
        logic [4:0] c;
        logic       f;
        c = 5'd0;
        f = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!f) begin
                if (v[i]) f = 1'b1;
                else      c = c + 5'd1;
            end
        end
        return c;
    endfunction

    // Round to nearest even and pack; a carry out of the fraction bumps the
    // exponent, which also turns the largest subnormal into the smallest normal.
    function automatic logic [31:0] fisr_pack(input t_rnd r);
        logic        inc;
        logic [30:0] mag;
        logic [31:0] res;
        inc = r.g & (r.st | r.m[0]);
        mag = {r.ef, r.m[22:0]} + {30'd0, inc};
        case (r.cls)
            CLS_NAN:  res = FP_QNAN;
            CLS_INF:  res = {r.sign, 8'hFF, 23'd0};
            CLS_ZERO: res = {r.sign, 31'd0};
            default: begin
                if (r.ovf) res = {r.sign, 8'hFF, 23'd0};
                else       res = {r.sign, mag};
            end
        endcase
        return res;
    endfunction

endpackage

>>> hdl/fisr_if.sv
// ----------------------------------------------------------------------------
// fisr_if
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
interface fisr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_bits;
    modport source (output valid, output operand_bits, input ready);
    modport sink   (input valid, input operand_bits, output ready);
endinterface

interface fisr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

>>> hdl/fisr_fop.sv
// ----------------------------------------------------------------------------
// fisr_fop
// Three-stage binary32 multiply or add with round to nearest even.
// ----------------------------------------------------------------------------
module fisr_fop #(
    parameter bit IS_ADD = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [63:0] i_side,
    output logic        o_vld,
    output logic [31:0] o_res,
    output logic [63:0] o_side
);
    import fisr_pkg::*;

    logic [2:0]  r_vld;
    logic [63:0] r_side1;
    logic [63:0] r_side2;
    logic [63:0] r_side3;
    t_rnd        r_rnd;
    t_rnd        n_rnd;
    logic [31:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'd0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            r_rnd   <= n_rnd;
            r_res   <= fisr_pack(r_rnd);
        end
    end

    generate
        if (IS_ADD) begin : g_add
            logic        r_sign;
            logic        r_zsign;
            logic        r_sub;
            t_cls        r_cls;
            logic [7:0]  r_eb;
            logic [26:0] r_big;
            logic [26:0] r_small;

            logic        n_sign;
            t_cls        n_cls;
            logic [7:0]  n_eb;
            logic [26:0] n_big;
            logic [26:0] n_small;
            t_cls        ca;
            t_cls        cb;
            logic        swap;
            logic [31:0] vb;
            logic [31:0] vs;
            logic [7:0]  es;
            logic [7:0]  d;
            logic [26:0] sm;
            logic [26:0] lost;

            always_comb begin
                ca   = fisr_class(i_a);
                cb   = fisr_class(i_b);
                swap = i_b[30:0] > i_a[30:0];
                vb   = swap ? i_b : i_a;
                vs   = swap ? i_a : i_b;
                n_eb = (vb[30:23] == 8'd0) ? 8'd1 : vb[30:23];
                es   = (vs[30:23] == 8'd0) ? 8'd1 : vs[30:23];
                d    = n_eb - es;
                n_big = {(vb[30:23] != 8'd0), vb[22:0], 3'b000};
                sm    = {(vs[30:23] != 8'd0), vs[22:0], 3'b000};
                if (d >= 8'd27) begin
                    lost    = 27'd0;
                    n_small = {26'd0, (sm != 27'd0)};
                end else begin
                    lost    = sm & ~({27{1'b1}} << d[4:0]);
                    n_small = (sm >> d[4:0]) | {26'd0, (lost != 27'd0)};
                end
                n_sign = vb[31];
                if (ca == CLS_NAN || cb == CLS_NAN ||
                    (ca == CLS_INF && cb == CLS_INF && i_a[31] != i_b[31])) begin
                    n_cls = CLS_NAN;
                end else if (ca == CLS_INF) begin
                    n_cls  = CLS_INF;
                    n_sign = i_a[31];
                end else if (cb == CLS_INF) begin
                    n_cls  = CLS_INF;
                    n_sign = i_b[31];
                end else begin
                    n_cls = CLS_NUM;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sign  <= n_sign;
                    r_zsign <= i_a[31] & i_b[31];
                    r_sub   <= i_a[31] ^ i_b[31];
                    r_cls   <= n_cls;
                    r_eb    <= n_eb;
                    r_big   <= n_big;
                    r_small <= n_small;
                end
            end

            logic [27:0] s;
            logic [26:0] sn;
            logic [4:0]  lz;
            logic [8:0]  e;

            always_comb begin
                s  = r_sub ? ({1'b0, r_big} - {1'b0, r_small})
                           : ({1'b0, r_big} + {1'b0, r_small});
                lz = fisr_lzc27(s[26:0]);
                if (s[27]) begin
                    sn = {s[27:2], s[1] | s[0]};
                    e  = {1'b0, r_eb} + 9'd1;
                end else if (r_eb > {3'd0, lz}) begin
                    sn = s[26:0] << lz;
                    e  = {1'b0, r_eb} - {4'd0, lz};
                end else begin
                    sn = s[26:0] << (r_eb - 8'd1);
                    e  = 9'd0;
                end
                n_rnd.sign = r_sign;
                n_rnd.cls  = r_cls;
                if (r_cls == CLS_NUM && s == 28'd0) begin
                    n_rnd.cls  = CLS_ZERO;
                    n_rnd.sign = r_zsign;
                end
                n_rnd.ovf = e >= 9'd255;
                n_rnd.ef  = e[7:0];
                n_rnd.m   = sn[26:3];
                n_rnd.g   = sn[2];
                n_rnd.st  = sn[1] | sn[0];
            end
        end else begin : g_mul
            logic        r_sign;
            t_cls        r_cls;
            logic [8:0]  r_esum;
            logic [47:0] r_prod;

            t_cls        ca;
            t_cls        cb;
            t_cls        n_cls;
            logic [7:0]  ea;
            logic [7:0]  eb;

            always_comb begin
                ca = fisr_class(i_a);
                cb = fisr_class(i_b);
                ea = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
                eb = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
                if (ca == CLS_NAN || cb == CLS_NAN ||
                    (ca == CLS_INF && cb == CLS_ZERO) ||
                    (ca == CLS_ZERO && cb == CLS_INF)) begin
                    n_cls = CLS_NAN;
                end else if (ca == CLS_INF || cb == CLS_INF) begin
                    n_cls = CLS_INF;
                end else if (ca == CLS_ZERO || cb == CLS_ZERO) begin
                    n_cls = CLS_ZERO;
                end else begin
                    n_cls = CLS_NUM;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sign <= i_a[31] ^ i_b[31];
                    r_cls  <= n_cls;
                    r_esum <= {1'b0, ea} + {1'b0, eb};
                    r_prod <= {(i_a[30:23] != 8'd0), i_a[22:0]} *
                              {(i_b[30:23] != 8'd0), i_b[22:0]};
                end
            end

            logic [5:0]         lz;
            logic signed [10:0] e;
            logic [8:0]         rs9;
            logic [4:0]         rs;
            logic [95:0]        v;

            always_comb begin
                lz  = fisr_lzc48(r_prod);
                e   = $signed({2'b00, r_esum}) - 11'sd126 - $signed({5'd0, lz});
                rs9 = 9'd127 - r_esum;
                rs  = (rs9 > 9'd25) ? 5'd25 : rs9[4:0];
                if (e >= 11'sd1) begin
                    v = {r_prod << lz, 48'd0};
                end else if (r_esum >= 9'd127) begin
                    v = {r_prod << (r_esum - 9'd127), 48'd0};
                end else begin
                    v = {r_prod, 48'd0} >> rs;
                end
                n_rnd.sign = r_sign;
                n_rnd.cls  = r_cls;
                n_rnd.ovf  = e >= 11'sd255;
                n_rnd.ef   = (e >= 11'sd1) ? e[7:0] : 8'd0;
                n_rnd.m    = v[95:72];
                n_rnd.g    = v[71];
                n_rnd.st   = v[70:0] != 71'd0;
            end
        end
    endgenerate

    assign o_vld  = r_vld[2];
    assign o_res  = r_res;
    assign o_side = r_side3;

endmodule

>>> hdl/fast_inverse_sqrt.sv
// ----------------------------------------------------------------------------
// fast_inverse_sqrt
// Pipelined binary32 approximate reciprocal square root with two Newton steps.
// ----------------------------------------------------------------------------
// The unit takes one binary32 word per cycle while the output side does not
// stall and returns its approximate reciprocal square root, also at one word
// per cycle. The pipeline is built of nine floating-point operations of three
// register stages each (one halving multiply, then per Newton step two
// multiplies, one subtraction from 1.5 and one final multiply) plus one output
// register that maps every NaN result to the canonical quiet NaN. The whole
// pipeline advances together whenever the output register is empty or its
// word is being taken, so a stall on the output side holds every word in
// place and the input is ready in exactly those cycles.
module fast_inverse_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fisr_in_if.sink       i_in,
    fisr_out_if.source    o_out
);
    import fisr_pkg::*;

    localparam int NOPS = 9;

    logic              en;
    logic [NOPS:0]     vld;
    logic [31:0]       res  [0:NOPS];
    logic [63:0]       side [0:NOPS];
    logic [31:0]       op_a [0:NOPS-1];
    logic [31:0]       op_b [0:NOPS-1];
    logic [63:0]       op_s [0:NOPS-1];
    logic [31:0]       seed;
    logic              r_out_vld;
    logic [31:0]       r_out_bits;
    logic [31:0]       fin;

    // The whole pipeline moves as one; the output register is the only
    // place where a finished word waits for the consumer.
    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // Integer seed: magic constant minus the operand shifted right
    // arithmetically, wrapping modulo 2^32.
    assign seed = MAGIC - {i_in.operand_bits[31], i_in.operand_bits[31:1]};

    assign vld[0]  = i_in.valid;
    assign res[0]  = i_in.operand_bits;
    assign side[0] = {32'd0, seed};

    // Operand routing. The side word carries {n, y} alongside each item.
    // Op 0 forms n = 0.5 * x; then each Newton step is ny = n * y,
    // nyy = ny * y, corr = 1.5 - nyy and finally y = y * corr.
    assign op_a[0] = res[0];
    assign op_b[0] = FP_HALF;
    assign op_s[0] = side[0];

    assign op_a[1] = res[1];
    assign op_b[1] = side[1][31:0];
    assign op_s[1] = {res[1], side[1][31:0]};

    genvar k;
    generate
        for (k = 2; k < NOPS; k++) begin : g_route
            if ((k - 1) % 4 == 0) begin : g_ny
                assign op_a[k] = side[k][63:32];
                assign op_b[k] = res[k];
                assign op_s[k] = {side[k][63:32], res[k]};
            end else if ((k - 1) % 4 == 1) begin : g_nyy
                assign op_a[k] = res[k];
                assign op_b[k] = side[k][31:0];
                assign op_s[k] = side[k];
            end else if ((k - 1) % 4 == 2) begin : g_corr
                // 1.5 - nyy is an addition with the sign of nyy flipped.
                assign op_a[k] = FP_1P5;
                assign op_b[k] = {~res[k][31], res[k][30:0]};
                assign op_s[k] = side[k];
            end else begin : g_upd
                assign op_a[k] = side[k][31:0];
                assign op_b[k] = res[k];
                assign op_s[k] = side[k];
            end
        end

        for (k = 0; k < NOPS; k++) begin : g_op
            fisr_fop #(
                .IS_ADD ((k % 4) == 3)
            ) u_fop (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_vld   (vld[k]),
                .i_a     (op_a[k]),
                .i_b     (op_b[k]),
                .i_side  (op_s[k]),
                .o_vld   (vld[k+1]),
                .o_res   (res[k+1]),
                .o_side  (side[k+1])
            );
        end
    endgenerate

    // Any NaN leaving the last stage is replaced by the canonical quiet NaN,
    // so the sign and payload never depend on how NaNs traveled.
    assign fin = (res[NOPS][30:23] == 8'hFF && res[NOPS][22:0] != 23'd0)
               ? FP_QNAN : res[NOPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= vld[NOPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bits <= fin;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.result_bits = r_out_bits;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reciprocal square root pipeline.
//
// Operand words go in on one valid/ready channel and result words come out on
// another. The bench works out each expected result with a bit-exact binary32
// model. That model has its own multiply and add with round-to-nearest-even,
// and it keeps subnormals. Each result word is checked in order. The run is a
// short list of special operands, followed by random words sent through four
// idle and stall phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fisr_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    fisr_in_if  in_if ();
    fisr_out_if out_if ();

    fast_inverse_sqrt u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Expected result words, oldest first.
    logic [31:0] pending_rsqrt[$];

    int idle_pct;
    int stall_pct;
    int mismatches;
    int words_sent;
    int words_checked;
    int cycles;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Binary32 arithmetic model.
    // ------------------------------------------------------------------------

    function automatic logic f32_is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic f32_is_inf(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    // Splits a finite value into an integer significand and a power of two, so
    // that the value is sig * 2^ex. A subnormal takes the exponent of the
    // smallest normal, but it has no hidden bit.
    function automatic void f32_split(input logic [31:0] v, output logic [63:0] sig,
                                      output int ex);
        sig = (v[30:23] == 8'd0) ? {41'd0, v[22:0]} : {40'd0, 1'b1, v[22:0]};
        ex  = ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150;
    endfunction

    // Rounds sign * mag * 2^ex to binary32 with round-to-nearest-even.
    function automatic logic [31:0] f32_round(input logic sgn, input logic [63:0] mag,
                                              input int ex);
        int           msb;
        int           sh;
        int           biased;
        logic [127:0] ext;
        logic [63:0]  q;
        logic         g;
        logic         st;
        if (mag == 64'd0) return {sgn, 31'd0};
        msb = 63;
        while (!mag[msb]) msb--;
        // Keep 24 bits. Keep fewer when the value falls below the normal range,
        // because the lowest stored bit cannot weigh less than 2^-149.
        sh = msb - 23;
        if (sh < -149 - ex) sh = -149 - ex;
        if (sh <= 0) begin
            q  = mag << (-sh);
            g  = 1'b0;
            st = 1'b0;
        end else if (sh > 64) begin
            q  = 64'd0;
            g  = 1'b0;
            st = 1'b1;
        end else begin
            ext = {mag, 64'd0} >> sh;
            q   = ext[127:64];
            g   = ext[63];
            st  = |ext[62:0];
        end
        if (g && (st || q[0])) q = q + 64'd1;
        if (q[24]) begin
            q  = q >> 1;
            sh = sh + 1;
        end
        if (!q[23]) return {sgn, 8'h00, q[22:0]};
        biased = ex + sh + 150;
        if (biased >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, biased[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        int          ea;
        int          eb;
        logic        sgn;
        sgn = a[31] ^ b[31];
        if (f32_is_nan(a) || f32_is_nan(b)) return FP_QNAN;
        if ((f32_is_inf(a) && b[30:0] == 31'd0) || (f32_is_inf(b) && a[30:0] == 31'd0))
            return FP_QNAN;
        if (f32_is_inf(a) || f32_is_inf(b)) return {sgn, 8'hFF, 23'd0};
        f32_split(a, ma, ea);
        f32_split(b, mb, eb);
        return f32_round(sgn, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] t;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] big;
        logic [63:0] lil;
        logic [63:0] mag;
        int          ea;
        int          eb;
        int          ex;
        logic        sgn;
        if (f32_is_nan(a) || f32_is_nan(b)) return FP_QNAN;
        if (f32_is_inf(a) && f32_is_inf(b) && (a[31] != b[31])) return FP_QNAN;
        if (f32_is_inf(a)) return a;
        if (f32_is_inf(b)) return b;
        if (a[30:23] < b[30:23]) begin
            t = a;
            a = b;
            b = t;
        end
        f32_split(a, ma, ea);
        f32_split(b, mb, eb);
        // When the gap in exponents is large, the smaller operand only adds a
        // sticky bit below the guard position.
        if (ea - eb > 38) begin
            big = ma << 38;
            lil = (mb != 64'd0) ? 64'd1 : 64'd0;
            ex  = ea - 38;
        end else begin
            big = ma << (ea - eb);
            lil = mb;
            ex  = eb;
        end
        if (a[31] == b[31]) begin
            mag = big + lil;
            sgn = a[31];
        end else if (big >= lil) begin
            mag = big - lil;
            sgn = a[31];
        end else begin
            mag = lil - big;
            sgn = b[31];
        end
        // An exact zero sum is +0, unless both operands were -0.
        if (mag == 64'd0) sgn = a[31] & b[31];
        return f32_round(sgn, mag, ex);
    endfunction

    function automatic logic [31:0] newton_refine(input logic [31:0] n, input logic [31:0] y);
        logic [31:0] nyy;
        nyy = f32_mul(f32_mul(n, y), y);
        return f32_mul(y, f32_add(FP_1P5, {~nyy[31], nyy[30:0]}));
    endfunction

    // Expected result word for one operand word.
    function automatic logic [31:0] rsqrt_approx(input logic [31:0] x);
        logic [31:0] n;
        logic [31:0] y;
        n = f32_mul(FP_HALF, x);
        // Arithmetic shift of the raw bits. The subtraction wraps at 32 bits.
        y = MAGIC - {x[31], x[31:1]};
        y = newton_refine(n, y);
        y = newton_refine(n, y);
        return f32_is_nan(y) ? FP_QNAN : y;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and checking.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("tb: mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // Sends one operand word. The word may first wait out a random idle gap.
    // The call returns at the edge that accepts the word, with valid still
    // high. The next call can then keep valid high, or it can drop valid for
    // a gap.
    task automatic send_operand(input logic [31:0] w);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.operand_bits <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_rsqrt.push_back(rsqrt_approx(w));
        words_sent++;
    endtask

    // The receiver stalls at random. Each result word is checked at the edge
    // that accepts it, against the oldest expected word.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_rsqrt.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", out_if.result_bits));
            end else begin
                if (out_if.result_bits !== pending_rsqrt[0])
                    report_mismatch($sformatf("result_bits got %h expected %h",
                                              out_if.result_bits, pending_rsqrt[0]));
                void'(pending_rsqrt.pop_front());
                words_checked++;
            end
        end
    end

    // Watchdog that ends a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: timeout with %0d results outstanding", pending_rsqrt.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Operands at the edges of the format. Also negative values, NaNs, and an
    // operand whose seed is a NaN pattern.
    task automatic test_special_operands();
        logic [31:0] ops[$];
        ops = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                32'h7FC0_0000, 32'h7F80_0001, 32'hFFC1_2345, 32'h0000_0001,
                32'h0000_0002, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                32'h7F00_0000, 32'h3F80_0000, 32'h4080_0000, 32'h3E80_0000,
                32'h3F7F_FFFF, 32'hBF80_0000, 32'h8000_0001, 32'hFFFF_FFFF,
                32'hBEEE_B50C, 32'hFF7F_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        idle_pct  = 0;
        stall_pct = 0;
        foreach (ops[i]) send_operand(ops[i]);
    endtask

    // Random words in one idle/stall phase. Most of them are positive normal
    // numbers, which is the typical use. The rest are random patterns and
    // values with an exponent of zero or of all ones.
    task automatic test_random_phase(input int count, input int idle, input int stall);
        logic [31:0] w;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) begin
            w = $urandom;
            case ($urandom_range(9))
                0, 1, 2: ;
                3:       w[30:23] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                default: w[31]    = 1'b0;
            endcase
            send_operand(w);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.operand_bits = 32'd0;
        out_if.ready       = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        mismatches         = 0;
        words_sent         = 0;
        words_checked      = 0;
        cycles             = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_operands();
        test_random_phase(210, 0, 0);
        test_random_phase(210, 62, 0);
        test_random_phase(210, 0, 62);
        test_random_phase(210, 38, 38);
        in_if.valid <= 1'b0;

        // Wait for the pipeline to drain. Then allow some more cycles, so that
        // any stray extra word would show up.
        wait (pending_rsqrt.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d operand words sent, %0d results checked", words_sent,
                 words_checked);
        $display("tb: special operands and four idle/stall phases, %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
